[rtl/vmh_pkg.sv]
package vmh_pkg;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_HOLD   = 2'd1,
        MODE_ALARM  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SUB_DRIFT  = 2'd0,
        SUB_ALIGN  = 2'd1,
        SUB_RETURN = 2'd2
    } sub_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_MANUAL = 2'd1,
        OP_HOLD   = 2'd2,
        OP_ALARM  = 2'd3
    } op_t;

    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STATUS_INTERVAL = 4'd0,
        REG_HOLD_TIMEOUT    = 4'd1,
        REG_MANUAL_MIN      = 4'd2,
        REG_MANUAL_MAX      = 4'd3,
        REG_HOLD_MIN        = 4'd4,
        REG_HOLD_MAX        = 4'd5,
        REG_DEPART_DIST     = 4'd6,
        REG_ARRIVE_DIST     = 4'd7
    } reg_idx_t;

    localparam int THRUST_W = 7;
    localparam int ANGLE_W  = 12;

    typedef struct packed {
        logic signed [THRUST_W-1:0] left;
        logic signed [THRUST_W-1:0] right;
        logic                       valid;
    } thrust_t;

    localparam logic [31:0] SIGNAL_LOSS_MS = 32'd1000;
    localparam logic [ANGLE_W-1:0] ALIGN_LIMIT_DDEG = 12'd900;
    localparam logic [ANGLE_W-1:0] ON_COURSE_DDEG   = 12'd150;

    localparam logic signed [THRUST_W-1:0] THRUST_ZERO  = 7'sd0;
    localparam logic signed [THRUST_W-1:0] THRUST_ALIGN = 7'sd26;
    localparam logic signed [THRUST_W-1:0] THRUST_CRUISE = 7'sd25;
    localparam logic signed [THRUST_W-1:0] THRUST_FULL  = 7'sd50;

    localparam logic [31:0] RST_STATUS_INTERVAL = 32'd30000;
    localparam logic [31:0] RST_HOLD_TIMEOUT    = 32'd30000;
    localparam logic [15:0] RST_MANUAL_MIN      = 16'd800;
    localparam logic [15:0] RST_MANUAL_MAX      = 16'd1000;
    localparam logic [15:0] RST_HOLD_MIN        = 16'd1800;
    localparam logic [15:0] RST_HOLD_MAX        = 16'd2100;
    localparam logic [15:0] RST_DEPART_DIST     = 16'd100;
    localparam logic [15:0] RST_ARRIVE_DIST     = 16'd40;

endpackage

[rtl/vmh_homing.sv]
module vmh_homing (
    input  vmh_pkg::sub_t             substate,
    input  logic [15:0]               distance_dm,
    input  logic [vmh_pkg::ANGLE_W-1:0] bearing_ddeg,
    input  logic [vmh_pkg::ANGLE_W-1:0] heading_ddeg,
    input  logic [15:0]               depart_distance,
    input  logic [15:0]               arrive_distance,
    output vmh_pkg::sub_t             substate_next,
    output vmh_pkg::thrust_t          thrust
);
    import vmh_pkg::*;

    logic signed [ANGLE_W:0] diff;
    logic signed [ANGLE_W:0] diff_neg;
    logic [ANGLE_W-1:0]      mag;
    logic                    turn_pos;

    // plain difference, no wrap at 360 degrees
    assign diff     = $signed({1'b0, bearing_ddeg}) - $signed({1'b0, heading_ddeg});
    assign diff_neg = -diff;
    assign mag      = diff[ANGLE_W] ? diff_neg[ANGLE_W-1:0] : diff[ANGLE_W-1:0];
    assign turn_pos = (heading_ddeg < bearing_ddeg);

    always_comb begin
        substate_next = substate;
        thrust.valid  = 1'b1;
        thrust.left   = THRUST_ZERO;
        thrust.right  = THRUST_ZERO;
        unique case (substate)
            SUB_DRIFT: begin
                if (distance_dm > depart_distance) begin
                    substate_next = SUB_ALIGN;
                end
            end
            SUB_ALIGN: begin
                if (mag <= ALIGN_LIMIT_DDEG) begin
                    substate_next = SUB_RETURN;
                end else if (turn_pos) begin
                    thrust.left  = THRUST_ALIGN;
                    thrust.right = THRUST_ALIGN;
                end else begin
                    thrust.left  = -THRUST_ALIGN;
                    thrust.right = -THRUST_ALIGN;
                end
            end
            default: begin
                if (mag <= ON_COURSE_DDEG) begin
                    thrust.left  = THRUST_CRUISE;
                    thrust.right = -THRUST_CRUISE;
                end else if (turn_pos) begin
                    thrust.left  = THRUST_FULL;
                    thrust.right = -THRUST_CRUISE;
                end else begin
                    thrust.left  = THRUST_CRUISE;
                    thrust.right = -THRUST_FULL;
                end
                // a large angle error wins over arrival
                if (mag > ALIGN_LIMIT_DDEG) begin
                    substate_next = SUB_ALIGN;
                end else if (distance_dm <= arrive_distance) begin
                    substate_next = SUB_DRIFT;
                end
            end
        endcase
    end

endmodule

[rtl/vessel_mode_and_homing_controller_unit.sv]
// Vessel mode and homing controller.
// One transaction on the s_ stream is one control tick: RC pulse width, time
// stamps, receiver and sensor flags, distance and angles to home, and in
// s_tuser a forced-mode operation. Each tick yields exactly one transaction
// on the m_ stream with the new mode, hold substate, thruster pair and the
// event strobes (save home, water alert, alarm status).
// The cfg_ channel writes the timing, pulse-window and distance registers;
// write only while no tick is in flight. cfg_ready is always high, and an
// index past the last register is accepted and dropped.
// There are two register stages, the input register and the result register;
// m_tvalid is the valid flag of the result register.
// All tick logic sits between the input and result registers and the
// mode, substate and time stamps update at the same edge that loads the
// result, so with m_tready high one tick per cycle is sustained back to back.
// If the receiver stalls, the result register holds and the input register
// still takes one more tick; s_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both stages, puts the vessel in
// manual mode, drifting, with both time stamps at zero, and restores the
// register defaults.
module vessel_mode_and_homing_controller_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pulse_width_us[15:0], now_ms[47:16], last_signal_ms[79:48], gnss_fix[80],
    // controller_connected[81], water_detected[82], distance_dm[98:83],
    // bearing_ddeg[110:99], heading_ddeg[122:111], zero[127:123]
    input  logic [127:0]                  s_tdata,
    // operation[1:0]
    input  logic [1:0]                    s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // mode[1:0], substate[3:2], thrust_left[10:4], thrust_right[17:11],
    // thrust_valid[18], manual_drive[19], save_position[20],
    // send_water_alert[21], send_status[22], zero[23]
    output logic [23:0]                   m_tdata,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vmh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import vmh_pkg::*;

    // ---------------- configuration registers ----------------
    logic [31:0] status_interval_reg, hold_timeout_reg;
    logic [15:0] manual_min_reg, manual_max_reg, hold_min_reg, hold_max_reg;
    logic [15:0] depart_dist_reg, arrive_dist_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_interval_reg <= RST_STATUS_INTERVAL;
            hold_timeout_reg    <= RST_HOLD_TIMEOUT;
            manual_min_reg      <= RST_MANUAL_MIN;
            manual_max_reg      <= RST_MANUAL_MAX;
            hold_min_reg        <= RST_HOLD_MIN;
            hold_max_reg        <= RST_HOLD_MAX;
            depart_dist_reg     <= RST_DEPART_DIST;
            arrive_dist_reg     <= RST_ARRIVE_DIST;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_STATUS_INTERVAL: status_interval_reg <= cfg_data;
                REG_HOLD_TIMEOUT:    hold_timeout_reg    <= cfg_data;
                REG_MANUAL_MIN:      manual_min_reg      <= cfg_data[15:0];
                REG_MANUAL_MAX:      manual_max_reg      <= cfg_data[15:0];
                REG_HOLD_MIN:        hold_min_reg        <= cfg_data[15:0];
                REG_HOLD_MAX:        hold_max_reg        <= cfg_data[15:0];
                REG_DEPART_DIST:     depart_dist_reg     <= cfg_data[15:0];
                REG_ARRIVE_DIST:     arrive_dist_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic in_valid_reg, out_valid_reg;
    logic advance;      // result register can load this cycle
    logic fire;         // a tick moves from input register to result register

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // ---------------- input register ----------------
    op_t         op_reg;
    logic [15:0] pulse_reg;
    logic [31:0] now_reg, last_sig_reg;
    logic        fix_reg, ctrl_reg, water_reg;
    logic [15:0] dist_reg;
    logic [ANGLE_W-1:0] bearing_reg, heading_reg;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg       <= op_t'(s_tuser);
            pulse_reg    <= s_tdata[15:0];
            now_reg      <= s_tdata[47:16];
            last_sig_reg <= s_tdata[79:48];
            fix_reg      <= s_tdata[80];
            ctrl_reg     <= s_tdata[81];
            water_reg    <= s_tdata[82];
            dist_reg     <= s_tdata[98:83];
            bearing_reg  <= s_tdata[110:99];
            heading_reg  <= s_tdata[122:111];
        end
    end

    // ---------------- controller state ----------------
    mode_t       mode_reg, mode_next;
    sub_t        sub_reg, sub_next;
    logic [31:0] hold_entry_reg, hold_entry_next;
    logic [31:0] last_status_reg, last_status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_MANUAL;
            sub_reg         <= SUB_DRIFT;
            hold_entry_reg  <= '0;
            last_status_reg <= '0;
        end else if (fire) begin
            mode_reg        <= mode_next;
            sub_reg         <= sub_next;
            hold_entry_reg  <= hold_entry_next;
            last_status_reg <= last_status_next;
        end
    end

    // ---------------- forced mode, pulse windows, stops and alarms ----------------
    mode_t       mode_a, mode_b, mode_c;
    sub_t        sub_a, sub_b, sub_c;
    logic [31:0] he_a, he_b, ls_a, ls_c;
    logic        save_b, water_c, loss_c;
    logic        in_manual_win, in_hold_win;
    logic [31:0] sig_age, hold_age;

    assign in_manual_win = (pulse_reg >= manual_min_reg) && (pulse_reg <= manual_max_reg);
    assign in_hold_win   = (pulse_reg >= hold_min_reg) && (pulse_reg <= hold_max_reg);
    assign sig_age       = now_reg - last_sig_reg;

    always_comb begin
        // forced operation
        mode_a = mode_reg;
        sub_a  = sub_reg;
        he_a   = hold_entry_reg;
        ls_a   = last_status_reg;
        save_b = 1'b0;
        if (op_reg == OP_MANUAL && mode_reg != MODE_MANUAL) begin
            mode_a = MODE_MANUAL;
            sub_a  = SUB_DRIFT;
        end else if (op_reg == OP_HOLD && mode_reg != MODE_HOLD) begin
            save_b = (mode_reg == MODE_MANUAL) && fix_reg;
            mode_a = MODE_HOLD;
            he_a   = now_reg;
        end else if (op_reg == OP_ALARM && mode_reg != MODE_ALARM) begin
            mode_a = MODE_ALARM;
            sub_a  = SUB_DRIFT;
            ls_a   = now_reg;
        end

        // pulse windows; the hold window is still tested when already manual
        mode_b = mode_a;
        sub_b  = sub_a;
        he_b   = he_a;
        if (in_manual_win && mode_a != MODE_MANUAL) begin
            mode_b = MODE_MANUAL;
            sub_b  = SUB_DRIFT;
        end else if (in_hold_win && mode_a != MODE_HOLD) begin
            if (mode_a == MODE_MANUAL && fix_reg) begin
                save_b = 1'b1;
            end
            mode_b = MODE_HOLD;
            he_b   = now_reg;
        end
    end

    assign hold_age = now_reg - he_b;

    always_comb begin
        // signal loss stops the thrusters in manual mode
        loss_c = (mode_b == MODE_MANUAL) && (pulse_reg == 16'd0) && (sig_age > SIGNAL_LOSS_MS);
        mode_c  = mode_b;
        sub_c   = sub_b;
        ls_c    = ls_a;
        water_c = 1'b0;
        // hold timeout, then water; both end in alarm
        if (mode_b == MODE_HOLD && (hold_age >= hold_timeout_reg || water_reg)) begin
            // a timeout leaves hold first, so the water check no longer fires
            water_c = water_reg && (hold_age < hold_timeout_reg);
            mode_c  = MODE_ALARM;
            sub_c   = SUB_DRIFT;
            ls_c    = now_reg;
        end
    end

    // ---------------- homing ----------------
    sub_t    home_sub;
    thrust_t home_thrust;

    vmh_homing u_homing (
        .substate        (sub_c),
        .distance_dm     (dist_reg),
        .bearing_ddeg    (bearing_reg),
        .heading_ddeg    (heading_reg),
        .depart_distance (depart_dist_reg),
        .arrive_distance (arrive_dist_reg),
        .substate_next   (home_sub),
        .thrust          (home_thrust)
    );

    // ---------------- per-mode action ----------------
    thrust_t     thrust_d;
    logic        manual_drive_d, save_d, status_d;
    logic [31:0] status_age;

    assign status_age = now_reg - ls_c;

    always_comb begin
        mode_next        = mode_c;
        sub_next         = sub_c;
        hold_entry_next  = he_b;
        last_status_next = ls_c;
        thrust_d.valid   = loss_c;
        thrust_d.left    = THRUST_ZERO;
        thrust_d.right   = THRUST_ZERO;
        manual_drive_d   = 1'b0;
        save_d           = save_b;
        status_d         = 1'b0;
        unique case (mode_c)
            MODE_MANUAL: begin
                manual_drive_d = 1'b1;
                // remote gone: hold here and remember this spot
                if (!ctrl_reg) begin
                    mode_next       = MODE_HOLD;
                    hold_entry_next = now_reg;
                    save_d          = 1'b1;
                end
            end
            MODE_HOLD: begin
                // water already sent the vessel to alarm, so none is seen here
                sub_next = home_sub;
                thrust_d = home_thrust;
            end
            default: begin
                if (status_age >= status_interval_reg) begin
                    status_d         = 1'b1;
                    last_status_next = now_reg;
                end
            end
        endcase
    end

    // ---------------- result register ----------------
    logic [23:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {1'b0, status_d, water_c, save_d, manual_drive_d,
                             thrust_d.valid, thrust_d.right, thrust_d.left,
                             sub_next, mode_next};
        end
    end

    assign m_tdata = out_data_reg;

    // ---------------- assertions ----------------
    // the substate only moves away from drifting while holding position
    a_sub_drift_outside_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_HOLD |-> sub_reg == SUB_DRIFT)
        else $error("substate left drifting outside hold mode");

    // a water alert always lands in alarm mode
    a_water_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[21] |-> out_data_reg[1:0] == MODE_ALARM)
        else $error("water alert without alarm mode");

    // manual driving excludes alarm events in the same tick
    a_manual_no_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[19] |-> !out_data_reg[21] && !out_data_reg[22])
        else $error("manual drive together with an alarm event");

    // a tick that leaves the input register updates the controller state
    a_state_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> mode_reg == $past(mode_next) && sub_reg == $past(sub_next))
        else $error("controller state not updated by a tick");

endmodule

[dv/tb_vessel_mode_and_homing_controller_unit.sv]
module tb_vessel_mode_and_homing_controller_unit;
    import vmh_pkg::*;

    // One control tick as the sender sees it, before packing onto s_tdata/s_tuser
    typedef struct packed {
        op_t         op;
        logic [15:0] pulse;
        logic [31:0] now;
        logic [31:0] last_sig;
        logic        fix;
        logic        ctrl;
        logic        water;
        logic [15:0] dist_dm;
        logic [11:0] bearing;
        logic [11:0] heading;
    } tick_t;

    // One report of the block, field for field as it leaves on m_tdata
    typedef struct packed {
        mode_t                      mode;
        sub_t                       sub;
        logic signed [THRUST_W-1:0] left;
        logic signed [THRUST_W-1:0] right;
        logic                       thr_valid;
        logic                       drive;
        logic                       save;
        logic                       alert;
        logic                       status;
    } report_t;

    // Mode and homing predictor plus the queue of reports it still expects
    class vessel_scoreboard;
        report_t     expected_reports[$];
        int          errors;
        int          n_ticks;
        int          n_reports;
        int          n_return;
        int          n_status;
        int          n_alert;
        int          n_save;
        logic [31:0] status_iv;
        logic [31:0] hold_to;
        logic [15:0] man_min;
        logic [15:0] man_max;
        logic [15:0] hold_min;
        logic [15:0] hold_max;
        logic [15:0] depart;
        logic [15:0] arrive;
        mode_t       mode;
        sub_t        sub;
        logic [31:0] hold_stamp;
        logic [31:0] status_stamp;

        function new();
            status_iv    = RST_STATUS_INTERVAL;
            hold_to      = RST_HOLD_TIMEOUT;
            man_min      = RST_MANUAL_MIN;
            man_max      = RST_MANUAL_MAX;
            hold_min     = RST_HOLD_MIN;
            hold_max     = RST_HOLD_MAX;
            depart       = RST_DEPART_DIST;
            arrive       = RST_ARRIVE_DIST;
            mode         = MODE_MANUAL;
            sub          = SUB_DRIFT;
            hold_stamp   = '0;
            status_stamp = '0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_STATUS_INTERVAL: status_iv = v;
                REG_HOLD_TIMEOUT:    hold_to   = v;
                REG_MANUAL_MIN:      man_min   = v[15:0];
                REG_MANUAL_MAX:      man_max   = v[15:0];
                REG_HOLD_MIN:        hold_min  = v[15:0];
                REG_HOLD_MAX:        hold_max  = v[15:0];
                REG_DEPART_DIST:     depart    = v[15:0];
                REG_ARRIVE_DIST:     arrive    = v[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void go_alarm(logic [31:0] now_v);
            mode         = MODE_ALARM;
            sub          = SUB_DRIFT;
            status_stamp = now_v;
        endfunction

        function void set_thrust(inout report_t r, input logic signed [THRUST_W-1:0] l,
                                 input logic signed [THRUST_W-1:0] rt);
            r.left      = l;
            r.right     = rt;
            r.thr_valid = 1'b1;
        endfunction

        // Homing substate machine; the angle error is the raw difference, no wrap
        function void steer(tick_t t, inout report_t r);
            int diff;
            int mag;
            diff = int'(t.bearing) - int'(t.heading);
            mag  = (diff < 0) ? -diff : diff;
            case (sub)
                SUB_DRIFT: begin
                    set_thrust(r, THRUST_ZERO, THRUST_ZERO);
                    if (t.dist_dm > depart) sub = SUB_ALIGN;
                end
                SUB_ALIGN: begin
                    if (mag <= int'(ALIGN_LIMIT_DDEG)) begin
                        sub = SUB_RETURN;
                        set_thrust(r, THRUST_ZERO, THRUST_ZERO);
                    end else if (t.heading < t.bearing) begin
                        set_thrust(r, THRUST_ALIGN, THRUST_ALIGN);
                    end else begin
                        set_thrust(r, -THRUST_ALIGN, -THRUST_ALIGN);
                    end
                end
                default: begin
                    if (mag <= int'(ON_COURSE_DDEG))
                        set_thrust(r, THRUST_CRUISE, -THRUST_CRUISE);
                    else if (t.heading < t.bearing)
                        set_thrust(r, THRUST_FULL, -THRUST_CRUISE);
                    else
                        set_thrust(r, THRUST_CRUISE, -THRUST_FULL);
                    // arrival first, a large angle error overrides it
                    if (t.dist_dm <= arrive) sub = SUB_DRIFT;
                    if (mag > int'(ALIGN_LIMIT_DDEG)) sub = SUB_ALIGN;
                end
            endcase
        endfunction

        function void predict_tick(tick_t t);
            report_t     r;
            logic [31:0] dt;
            r = '0;
            n_ticks++;
            if (t.op == OP_MANUAL && mode != MODE_MANUAL) begin
                mode = MODE_MANUAL;
                sub  = SUB_DRIFT;
            end else if (t.op == OP_HOLD && mode != MODE_HOLD) begin
                if (mode == MODE_MANUAL && t.fix) r.save = 1'b1;
                mode       = MODE_HOLD;
                hold_stamp = t.now;
            end else if (t.op == OP_ALARM && mode != MODE_ALARM) begin
                go_alarm(t.now);
            end

            if (t.pulse >= man_min && t.pulse <= man_max && mode != MODE_MANUAL) begin
                mode = MODE_MANUAL;
                sub  = SUB_DRIFT;
            end else if (t.pulse >= hold_min && t.pulse <= hold_max && mode != MODE_HOLD) begin
                if (mode == MODE_MANUAL && t.fix) r.save = 1'b1;
                mode       = MODE_HOLD;
                hold_stamp = t.now;
            end

            dt = t.now - t.last_sig;
            if (mode == MODE_MANUAL && t.pulse == 16'd0 && dt > SIGNAL_LOSS_MS)
                set_thrust(r, THRUST_ZERO, THRUST_ZERO);

            dt = t.now - hold_stamp;
            if (mode == MODE_HOLD && dt >= hold_to) go_alarm(t.now);

            if (mode == MODE_HOLD && t.water) begin
                r.alert = 1'b1;
                go_alarm(t.now);
            end

            case (mode)
                MODE_MANUAL: begin
                    r.drive = 1'b1;
                    if (!t.ctrl) begin
                        mode       = MODE_HOLD;
                        hold_stamp = t.now;
                        r.save     = 1'b1;
                    end
                end
                MODE_HOLD: begin
                    steer(t, r);
                    if (t.water) begin
                        r.alert = 1'b1;
                        go_alarm(t.now);
                    end
                end
                default: begin
                    dt = t.now - status_stamp;
                    if (dt >= status_iv) begin
                        r.status     = 1'b1;
                        status_stamp = t.now;
                    end
                end
            endcase
            r.mode = mode;
            r.sub  = sub;
            expected_reports.push_back(r);
        endfunction

        function void check_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_report(logic [23:0] d);
            report_t e;
            if (expected_reports.size() == 0) begin
                $error("report %h arrived with no tick outstanding", d);
                errors++;
                return;
            end
            e = expected_reports.pop_front();
            n_reports++;
            if (e.sub == SUB_RETURN) n_return++;
            if (e.status) n_status++;
            if (e.alert) n_alert++;
            if (e.save) n_save++;
            check_field("mode", e.mode, d[1:0]);
            check_field("substate", e.sub, d[3:2]);
            check_field("thrust_left", e.left, $signed(d[10:4]));
            check_field("thrust_right", e.right, $signed(d[17:11]));
            check_field("thrust_valid", e.thr_valid, d[18]);
            check_field("manual_drive", e.drive, d[19]);
            check_field("save_position", e.save, d[20]);
            check_field("send_water_alert", e.alert, d[21]);
            check_field("send_status", e.status, d[22]);
            check_field("pad", 0, d[23]);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [127:0]         s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    vessel_scoreboard sb;
    tick_t            drv_tick = '0;   // copy of the tick currently on s_tdata
    logic [31:0]      clk_ms = 32'd0;  // running mission time for random ticks
    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b1;
    int               stall_left = 0;

    vessel_mode_and_homing_controller_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run
    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: stall in bursts, mostly short, now and then long
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(8, 30);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted tick, check every accepted report
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.predict_tick(drv_tick);
            if (m_tvalid && m_tready) sb.check_report(m_tdata);
        end
    end

    function automatic int sender_gap();
        int r;
        if (!tx_idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Present one tick and hold it until the block takes it; leave tvalid high
    // so back-to-back ticks need no second assignment in the same step
    task automatic send_tick(tick_t t);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= t.op;
        s_tdata  <= {5'b0, t.heading, t.bearing, t.dist_dm, t.water, t.ctrl, t.fix,
                     t.last_sig, t.now, t.pulse};
        drv_tick <= t;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drop tvalid and wait until every outstanding report has been checked;
    // first wait for a clock edge so the last accepted tick is already predicted
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all eight registers, in index order, while the block is idle
    task automatic apply_setting(input logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(reg_idx_t'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic tick_t mk(op_t op, int pulse, logic [31:0] now, logic [31:0] last_sig,
                                 bit fix, bit ctrl, bit water, int dist_dm, int bear, int head);
        tick_t t;
        t.op       = op;
        t.pulse    = 16'(pulse);
        t.now      = now;
        t.last_sig = last_sig;
        t.fix      = fix;
        t.ctrl     = ctrl;
        t.water    = water;
        t.dist_dm  = 16'(dist_dm);
        t.bearing  = 12'(bear);
        t.heading  = 12'(head);
        return t;
    endfunction

    // Random tick: mostly a plausible mission (time moving forward, pulses
    // near the windows, angles near each other), the rest pure noise
    function automatic tick_t rand_tick();
        tick_t t;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 70)      t.op = OP_NONE;
        else if (r < 80) t.op = OP_MANUAL;
        else if (r < 90) t.op = OP_HOLD;
        else             t.op = OP_ALARM;

        r = $urandom_range(0, 99);
        if (r < 70)      clk_ms = clk_ms + $urandom_range(0, 100);
        else if (r < 97) clk_ms = clk_ms + $urandom_range(0, 5000);
        else             clk_ms = $urandom();
        t.now = clk_ms;

        r = $urandom_range(0, 99);
        if (r < 60)      t.last_sig = clk_ms - $urandom_range(0, 1500);
        else if (r < 90) t.last_sig = clk_ms;
        else             t.last_sig = $urandom();

        case ($urandom_range(0, 9))
            0, 1: t.pulse = 16'd0;
            2:    t.pulse = 16'($urandom_range(sb.man_max, sb.man_min));
            3:    t.pulse = 16'($urandom_range(sb.hold_max, sb.hold_min));
            4: begin
                case ($urandom_range(0, 7))
                    0: t.pulse = sb.man_min - 16'd1;
                    1: t.pulse = sb.man_min;
                    2: t.pulse = sb.man_max;
                    3: t.pulse = sb.man_max + 16'd1;
                    4: t.pulse = sb.hold_min - 16'd1;
                    5: t.pulse = sb.hold_min;
                    6: t.pulse = sb.hold_max;
                    default: t.pulse = sb.hold_max + 16'd1;
                endcase
            end
            5:       t.pulse = 16'($urandom());
            default: t.pulse = 16'($urandom_range(1100, 1700));
        endcase

        t.fix   = 1'($urandom_range(0, 1));
        t.ctrl  = ($urandom_range(0, 99) < 90);
        t.water = ($urandom_range(0, 99) < 4);

        r = $urandom_range(0, 99);
        if (r < 40) begin
            t.dist_dm = 16'($urandom_range(0, 300));
        end else if (r < 60) begin
            case ($urandom_range(0, 3))
                0: t.dist_dm = sb.depart;
                1: t.dist_dm = sb.depart + 16'd1;
                2: t.dist_dm = sb.arrive;
                default: t.dist_dm = sb.arrive + 16'd1;
            endcase
        end else begin
            t.dist_dm = 16'($urandom());
        end

        r = $urandom_range(0, 99);
        if (r < 70) begin
            t.heading = 12'($urandom_range(0, 3599));
            t.bearing = 12'(t.heading + $urandom_range(0, 2000) - 12'd1000);
        end else if (r < 90) begin
            t.heading = 12'($urandom_range(0, 3599));
            t.bearing = 12'($urandom_range(0, 3599));
        end else begin
            t.heading = 12'($urandom());
            t.bearing = 12'($urandom());
        end
        return t;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            // reshuffle idling every 50 ticks so some stretches run flat out
            if (i % 50 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on <= ($urandom_range(0, 3) != 0);
            end
            send_tick(rand_tick());
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk at the reset defaults
        // signal loss in manual, then a gap of exactly 1000 ms (no loss)
        send_tick(mk(OP_NONE,   0,  5000,    0, 0, 1, 0,     0,    0,    0));
        send_tick(mk(OP_NONE,   0,  6000, 5000, 0, 1, 0,     0,    0,    0));
        // forced hold with fix saves home; far away so drift turns to align
        send_tick(mk(OP_HOLD, 1500, 7000, 7000, 1, 1, 0,   200,    0,    0));
        // forcing the current mode does nothing; align both ways
        send_tick(mk(OP_HOLD, 1500, 7100, 7100, 1, 1, 0, 65535, 3599,    0));
        send_tick(mk(OP_NONE, 1500, 7200, 7200, 0, 1, 0,   100,    0, 3599));
        // error of exactly 90 degrees starts the return
        send_tick(mk(OP_NONE, 1500, 7300, 7300, 0, 1, 0,   100, 1000,  100));
        // on course and arrived: back to drift
        send_tick(mk(OP_NONE, 1500, 7350, 7350, 0, 1, 0,    40,  150,    0));
        send_tick(mk(OP_NONE, 1500, 7360, 7360, 0, 1, 0,   101,  500,  500));
        send_tick(mk(OP_NONE, 1500, 7370, 7370, 0, 1, 0,   101,  500,  500));
        // off course by just over 15 degrees, then arrival beaten by a big error
        send_tick(mk(OP_NONE, 1500, 7380, 7380, 0, 1, 0,    41,  351,  200));
        send_tick(mk(OP_NONE, 1500, 7390, 7390, 0, 1, 0,     0,    0,  901));
        // water in hold, then the alarm status after a full interval
        send_tick(mk(OP_NONE, 1500, 7500, 7500, 0, 1, 1,     0,    0,    0));
        send_tick(mk(OP_NONE, 1500, 37500, 37500, 0, 1, 0,   0,    0,    0));
        send_tick(mk(OP_ALARM, 1500, 37600, 37600, 0, 1, 0,  0,    0,    0));
        send_tick(mk(OP_MANUAL, 1500, 37700, 37700, 0, 1, 0, 0,    0,    0));
        // window edges: hold without fix, manual, hold with fix
        send_tick(mk(OP_NONE, 1800, 37800, 37800, 0, 1, 0,   0,    0,    0));
        send_tick(mk(OP_NONE,  900, 37900, 37900, 0, 1, 0,   0,    0,    0));
        send_tick(mk(OP_NONE, 2100, 38000, 38000, 1, 1, 0,   0,    0,    0));
        // hold timeout
        send_tick(mk(OP_NONE, 2101, 68000, 68000, 0, 1, 0,   0,    0,    0));
        // forced hold from alarm saves nothing
        send_tick(mk(OP_HOLD,  799, 68100, 68100, 1, 1, 0,   0,    0,    0));
        // manual window, remote gone: straight back to hold with a save
        send_tick(mk(OP_NONE, 1000, 68200, 68200, 0, 0, 0,   0,    0,    0));
        // all fields at their top values
        send_tick(mk(OP_ALARM, 65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1,
                     65535, 4095, 4095));
        // angles outside 0..3599 taken as they come
        send_tick(mk(OP_NONE, 1801, 100, 100, 0, 1, 0,     65535, 4095,    0));
        send_tick(mk(OP_NONE,    0, 200, 32'h8000_0000, 0, 1, 0, 0, 2048, 4095));
        run_random(200);

        // Zero timers and overlapping pulse windows
        drain();
        apply_setting('{32'd0, 32'd0, 32'd1000, 32'd2000, 32'd1500, 32'd2500, 32'd0, 32'd0});
        run_random(200);

        // Upper extremes: timers at their largest value, manual window is the zero pulse
        drain();
        apply_setting('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd65535, 32'd65535,
                        32'd65535, 32'd65535});
        run_random(200);

        // Short timers so alarm status and hold timeouts come often
        drain();
        apply_setting('{32'd200, 32'd3000, 32'd900, 32'd1100, 32'd1900, 32'd2000,
                        32'd50, 32'd20});
        run_random(200);

        // Random setting, lowest nonzero timers allowed among the picks
        drain();
        apply_setting('{$urandom_range(1, 5000), $urandom_range(1, 20000),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 300), $urandom_range(0, 300)});
        run_random(200);

        // Back to the reset defaults
        drain();
        apply_setting('{RST_STATUS_INTERVAL, RST_HOLD_TIMEOUT, 32'(RST_MANUAL_MIN),
                        32'(RST_MANUAL_MAX), 32'(RST_HOLD_MIN), 32'(RST_HOLD_MAX),
                        32'(RST_DEPART_DIST), 32'(RST_ARRIVE_DIST)});
        run_random(200);

        drain();
        repeat (10) @(posedge aclk);

        $display("Checked %0d reports for %0d ticks across six register settings.",
                 sb.n_reports, sb.n_ticks);
        $display("Seen: %0d returning, %0d status, %0d water alerts, %0d home saves.",
                 sb.n_return, sb.n_status, sb.n_alert, sb.n_save);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/vmh_pkg.sv
rtl/vmh_homing.sv
rtl/vessel_mode_and_homing_controller_unit.sv
dv/tb_vessel_mode_and_homing_controller_unit.sv
